// ===== hw/rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry trip statistics package
// Widths, request types and shared constants for the trip statistics block.
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SUM_WIDTH   = 48;

    localparam int COUNT_W = 32;
    localparam int DIST_W  = 48;
    localparam int MEAN_W  = 32;
    localparam int TURN_W  = 32;

    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int SQ_W  = 2 * MAG_W + 1;
    localparam int RT_W  = MAG_W + 1;
    localparam int N_W   = 2 * RT_W;
    localparam int REM_W = RT_W + 1;

    localparam int ADD_W = ((SUM_WIDTH > RT_W) ? SUM_WIDTH : RT_W) + 1;

    localparam int HYP_CNT_W = $clog2(RT_W);
    localparam int DIV_CNT_W = $clog2(SUM_WIDTH);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [COORD_WIDTH-1:0] rate_x;
        logic signed [COORD_WIDTH-1:0] rate_y;
    } t_ots_in;

    typedef struct packed {
        logic [COUNT_W-1:0] samples_seen;
        logic [DIST_W-1:0]  distance_total;
        logic [MEAN_W-1:0]  mean_speed;
        logic [TURN_W-1:0]  peak_turn;
    } t_ots_out;

endpackage

// ===== hw/rtl/odometry_trip_statistics.sv =====
// ----------------------------------------------------------------------------
// Odometry trip statistics
// Accumulates travelled distance, mean speed and peak turn rate over a stream
// of odometry samples, using bit-serial square root and division units.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                Payload
//   in        input      i_in_valid / o_in_stall  i_in  (ots_pkg::t_ots_in)
//   out       output     o_out_valid / i_out_stall o_out (ots_pkg::t_ots_out)
//
// A request runs through the three hypotenuse units side by side and then the
// divider, and its result is loaded into the output register once that is free;
// the next request is taken only after that load, so one request is in work.
// Reset is synchronous and clears the count, sums and peak to zero; the mean
// and the output register are not reset.
// A stalled result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module odometry_trip_statistics (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ots_pkg::t_ots_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ots_pkg::t_ots_out o_out
);

    typedef enum logic [1:0] {S_IDLE, S_HYP, S_DIV, S_OUT} t_state;

    t_state                               r_state;
    logic                                 r_hyp_start;
    logic                                 r_div_start;
    logic                                 r_out_valid;
    ots_pkg::t_ots_out                    r_out;
    logic [ots_pkg::COUNT_W-1:0]          r_count;
    logic signed [ots_pkg::COORD_WIDTH-1:0] r_prev_x;
    logic signed [ots_pkg::COORD_WIDTH-1:0] r_prev_y;
    logic [ots_pkg::SUM_WIDTH-1:0]        r_dist_sum;
    logic [ots_pkg::SUM_WIDTH-1:0]        r_speed_sum;
    logic [ots_pkg::TURN_W-1:0]           r_peak;
    logic [ots_pkg::MEAN_W-1:0]           r_mean;
    logic [ots_pkg::MAG_W-1:0]            r_dx;
    logic [ots_pkg::MAG_W-1:0]            r_dy;
    logic [ots_pkg::MAG_W-1:0]            r_vx;
    logic [ots_pkg::MAG_W-1:0]            r_vy;
    logic [ots_pkg::MAG_W-1:0]            r_wx;
    logic [ots_pkg::MAG_W-1:0]            r_wy;

    logic                                 w_in_acc;
    logic                                 w_out_free;
    logic                                 w_done_dist;
    logic                                 w_done_speed;
    logic                                 w_done_turn;
    logic                                 w_div_done;
    logic [ots_pkg::RT_W-1:0]             w_root_dist;
    logic [ots_pkg::RT_W-1:0]             w_root_speed;
    logic [ots_pkg::RT_W-1:0]             w_root_turn;
    logic [ots_pkg::SUM_WIDTH-1:0]        w_quot;
    logic [ots_pkg::SUM_WIDTH-1:0]        n_dist_sum;
    logic [ots_pkg::SUM_WIDTH-1:0]        n_speed_sum;
    logic [ots_pkg::TURN_W-1:0]           w_turn;

    function automatic logic [ots_pkg::MAG_W-1:0] f_absdiff(
        input logic signed [ots_pkg::COORD_WIDTH-1:0] a,
        input logic signed [ots_pkg::COORD_WIDTH-1:0] b
    );
        logic signed [ots_pkg::MAG_W-1:0] d;
        d = ots_pkg::MAG_W'(a) - ots_pkg::MAG_W'(b);
        return d[ots_pkg::MAG_W-1] ? ots_pkg::MAG_W'(-d) : ots_pkg::MAG_W'(d);
    endfunction

    function automatic logic [ots_pkg::SUM_WIDTH-1:0] f_sat_add(
        input logic [ots_pkg::SUM_WIDTH-1:0] s,
        input logic [ots_pkg::RT_W-1:0]      v
    );
        logic [ots_pkg::ADD_W-1:0] t;
        t = ots_pkg::ADD_W'(s) + ots_pkg::ADD_W'(v);
        if (t > ots_pkg::ADD_W'({ots_pkg::SUM_WIDTH{1'b1}})) begin
            return '1;
        end
        return t[ots_pkg::SUM_WIDTH-1:0];
    endfunction

    function automatic logic [ots_pkg::DIST_W-1:0] f_clamp_dist(
        input logic [ots_pkg::SUM_WIDTH-1:0] v
    );
        logic [ots_pkg::SUM_WIDTH+ots_pkg::DIST_W-1:0] e;
        e = {{ots_pkg::DIST_W{1'b0}}, v};
        if (e > (ots_pkg::SUM_WIDTH + ots_pkg::DIST_W)'({ots_pkg::DIST_W{1'b1}})) begin
            return '1;
        end
        return e[ots_pkg::DIST_W-1:0];
    endfunction

    function automatic logic [ots_pkg::MEAN_W-1:0] f_clamp_mean(
        input logic [ots_pkg::SUM_WIDTH-1:0] v
    );
        logic [ots_pkg::SUM_WIDTH+ots_pkg::MEAN_W-1:0] e;
        e = {{ots_pkg::MEAN_W{1'b0}}, v};
        if (e > (ots_pkg::SUM_WIDTH + ots_pkg::MEAN_W)'({ots_pkg::MEAN_W{1'b1}})) begin
            return '1;
        end
        return e[ots_pkg::MEAN_W-1:0];
    endfunction

    function automatic logic [ots_pkg::TURN_W-1:0] f_clamp_turn(
        input logic [ots_pkg::RT_W-1:0] v
    );
        logic [ots_pkg::RT_W+ots_pkg::TURN_W-1:0] e;
        e = {{ots_pkg::TURN_W{1'b0}}, v};
        if (e > (ots_pkg::RT_W + ots_pkg::TURN_W)'({ots_pkg::TURN_W{1'b1}})) begin
            return '1;
        end
        return e[ots_pkg::TURN_W-1:0];
    endfunction

    ots_hypot u_hyp_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hyp_start),
        .i_a     (r_dx),
        .i_b     (r_dy),
        .o_done  (w_done_dist),
        .o_root  (w_root_dist)
    );

    ots_hypot u_hyp_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hyp_start),
        .i_a     (r_vx),
        .i_b     (r_vy),
        .o_done  (w_done_speed),
        .o_root  (w_root_speed)
    );

    ots_hypot u_hyp_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hyp_start),
        .i_a     (r_wx),
        .i_b     (r_wy),
        .o_done  (w_done_turn),
        .o_root  (w_root_turn)
    );

    ots_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_speed_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_in_acc = (r_state == S_IDLE) && i_in_valid;
        w_out_free = !r_out_valid || !i_out_stall;
        n_dist_sum = f_sat_add(r_dist_sum, w_root_dist);
        n_speed_sum = f_sat_add(r_speed_sum, w_root_speed);
        w_turn = f_clamp_turn(w_root_turn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hyp_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_dist_sum  <= '0;
            r_speed_sum <= '0;
            r_peak      <= '0;
        end else begin
            r_hyp_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_count != '1) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_prev_x    <= i_in.pos_x;
                        r_prev_y    <= i_in.pos_y;
                        r_hyp_start <= 1'b1;
                        r_state     <= S_HYP;
                    end
                end
                S_HYP: begin
                    if (w_done_dist && w_done_speed && w_done_turn) begin
                        if (r_count > ots_pkg::COUNT_W'(1)) begin
                            r_dist_sum <= n_dist_sum;
                        end
                        r_speed_sum <= n_speed_sum;
                        if (w_turn > r_peak) begin
                            r_peak <= w_turn;
                        end
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dx <= f_absdiff(i_in.pos_x, r_prev_x);
            r_dy <= f_absdiff(i_in.pos_y, r_prev_y);
            r_vx <= f_absdiff(i_in.vel_x, '0);
            r_vy <= f_absdiff(i_in.vel_y, '0);
            r_wx <= f_absdiff(i_in.rate_x, '0);
            r_wy <= f_absdiff(i_in.rate_y, '0);
        end
        if (r_state == S_DIV && w_div_done) begin
            r_mean <= f_clamp_mean(w_quot);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.samples_seen   <= r_count;
            r_out.distance_total <= f_clamp_dist(r_dist_sum);
            r_out.mean_speed     <= r_mean;
            r_out.peak_turn      <= r_peak;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The three hypotenuse units share a start and must finish together.
    a_hyp_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_dist == w_done_speed) && (w_done_speed == w_done_turn))
        else $error("hypotenuse units out of step");

    // A new result is loaded only at the end of a request's work.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !i_out_stall) && r_state != S_OUT |=> !$rose(r_out_valid))
        else $error("result loaded outside of the output state");

    // The sample count never goes down.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |=> (r_count >= $past(r_count)))
        else $error("sample count decreased");

    // The peak turn rate never goes down.
    a_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_peak != '0) |=> (r_peak >= $past(r_peak)))
        else $error("peak turn rate decreased");

    // The divider is started only after the hypotenuse units have finished.
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> $past(w_done_speed))
        else $error("divider started before the speed magnitude was ready");

endmodule

// ===== hw/rtl/ots_hypot.sv =====
// ----------------------------------------------------------------------------
// Bit-serial hypotenuse unit
// Squares two magnitudes one multiplier bit per cycle, then takes the floor
// square root of the sum two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ots_hypot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ots_pkg::MAG_W-1:0]  i_a,
    input  logic [ots_pkg::MAG_W-1:0]  i_b,
    output logic                       o_done,
    output logic [ots_pkg::RT_W-1:0]   o_root
);

    typedef enum logic [1:0] {S_IDLE, S_SQUARE, S_ROOT} t_state;

    t_state                            r_state;
    logic [ots_pkg::HYP_CNT_W-1:0]     r_cnt;
    logic                              r_done;
    logic [ots_pkg::SQ_W-1:0]          r_ma;
    logic [ots_pkg::SQ_W-1:0]          r_mb;
    logic [ots_pkg::MAG_W-1:0]         r_qa;
    logic [ots_pkg::MAG_W-1:0]         r_qb;
    logic [ots_pkg::SQ_W-1:0]          r_acc;
    logic [ots_pkg::N_W-1:0]           r_n;
    logic [ots_pkg::REM_W-1:0]         r_rem;
    logic [ots_pkg::RT_W-1:0]          r_root;

    logic [ots_pkg::SQ_W-1:0]          n_acc;
    logic [ots_pkg::REM_W+1:0]         w_rem_sh;
    logic [ots_pkg::REM_W+1:0]         w_trial;
    logic [ots_pkg::REM_W+1:0]         w_diff;
    logic                              w_fit;
    logic                              w_sq_last;
    logic                              w_rt_last;

    always_comb begin
        n_acc = r_acc + (r_qa[0] ? r_ma : '0) + (r_qb[0] ? r_mb : '0);
        w_rem_sh = {r_rem, r_n[ots_pkg::N_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_fit = (w_rem_sh >= w_trial);
        w_diff = w_rem_sh - w_trial;
        w_sq_last = (r_cnt == ots_pkg::HYP_CNT_W'(ots_pkg::MAG_W - 1));
        w_rt_last = (r_cnt == ots_pkg::HYP_CNT_W'(ots_pkg::RT_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    if (w_sq_last) begin
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ROOT: begin
                    if (w_rt_last) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_ma  <= ots_pkg::SQ_W'(i_a);
            r_mb  <= ots_pkg::SQ_W'(i_b);
            r_qa  <= i_a;
            r_qb  <= i_b;
            r_acc <= '0;
        end else if (r_state == S_SQUARE) begin
            r_ma  <= r_ma << 1;
            r_mb  <= r_mb << 1;
            r_qa  <= r_qa >> 1;
            r_qb  <= r_qb >> 1;
            r_acc <= n_acc;
            if (w_sq_last) begin
                r_n    <= ots_pkg::N_W'(n_acc);
                r_rem  <= '0;
                r_root <= '0;
            end
        end else if (r_state == S_ROOT) begin
            r_n <= r_n << 2;
            if (w_fit) begin
                r_rem  <= w_diff[ots_pkg::REM_W-1:0];
                r_root <= {r_root[ots_pkg::RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[ots_pkg::REM_W-1:0];
                r_root <= {r_root[ots_pkg::RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/ots_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of the speed sum by the sample count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module ots_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ots_pkg::SUM_WIDTH-1:0] i_dividend,
    input  logic [ots_pkg::COUNT_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [ots_pkg::SUM_WIDTH-1:0] o_quot
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                          r_state;
    logic [ots_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                            r_done;
    logic [ots_pkg::SUM_WIDTH-1:0]   r_q;
    logic [ots_pkg::COUNT_W-1:0]     r_rem;
    logic [ots_pkg::COUNT_W-1:0]     r_d;

    logic [ots_pkg::COUNT_W:0]       w_sh;
    logic [ots_pkg::COUNT_W:0]       w_diff;
    logic                            w_fit;
    logic                            w_last;

    always_comb begin
        w_sh = {r_rem, r_q[ots_pkg::SUM_WIDTH-1]};
        w_fit = (w_sh >= {1'b0, r_d});
        w_diff = w_sh - {1'b0, r_d};
        w_last = (r_cnt == ots_pkg::DIV_CNT_W'(ots_pkg::SUM_WIDTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_state == S_RUN) begin
            if (w_fit) begin
                r_rem <= w_diff[ots_pkg::COUNT_W-1:0];
                r_q   <= {r_q[ots_pkg::SUM_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[ots_pkg::COUNT_W-1:0];
                r_q   <= {r_q[ots_pkg::SUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== tb/sv/ots_trip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry trip statistics checker
// Watches the request and result channels of the trip statistics block. For
// every accepted request it works out the expected statistics and queues
// them; every accepted result is compared field by field with the oldest
// queued entry. Mismatches are printed one per line and counted.
// ----------------------------------------------------------------------------
module ots_trip_checker
    import ots_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_ots_in  i_in,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_ots_out i_out,
    output int       o_mismatches,
    output int       o_outstanding,
    output int       o_results
);

    localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_WIDTH) - 64'd1;
    localparam logic [63:0] DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;
    localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 64'd1;
    localparam logic [63:0] TURN_LIMIT = (64'd1 << TURN_W) - 64'd1;

    logic signed [COORD_WIDTH-1:0] last_x;
    logic signed [COORD_WIDTH-1:0] last_y;
    logic [COUNT_W-1:0]            trip_count;
    logic [63:0]                   dist_acc;
    logic [63:0]                   speed_acc;
    logic [TURN_W-1:0]             peak_rate;
    t_ots_out                      stats_due[$];
    int                            mismatches;
    int                            results;

    // Floor of the length of the vector (a, b), taken on the exact sum of squares.
    function automatic logic [63:0] vector_length(input logic [63:0] a, input logic [63:0] b);
        logic [71:0] wa;
        logic [71:0] wb;
        logic [71:0] n;
        logic [71:0] c;
        logic [71:0] r;
        wa = a;
        wb = b;
        n  = wa * wa + wb * wb;
        r  = '0;
        for (int i = 35; i >= 0; i--) begin
            c = r | (72'd1 << i);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] abs_wide(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_LIMIT) ? SUM_LIMIT : s;
    endfunction

    task automatic advance_trip(input t_ots_in s, output t_ots_out r);
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic [63:0]        mean;
        logic [63:0]        turn;
        nx = s.pos_x;
        ny = s.pos_y;
        px = last_x;
        py = last_y;
        if (trip_count != '1) begin
            trip_count = trip_count + 1'b1;
        end
        if (trip_count > 1) begin
            dist_acc = sum_sat(dist_acc, vector_length(abs_wide(nx - px), abs_wide(ny - py)));
        end
        last_x = s.pos_x;
        last_y = s.pos_y;
        speed_acc = sum_sat(speed_acc, vector_length(abs_wide(s.vel_x), abs_wide(s.vel_y)));
        mean = speed_acc / trip_count;
        if (mean > MEAN_LIMIT) begin
            mean = MEAN_LIMIT;
        end
        turn = vector_length(abs_wide(s.rate_x), abs_wide(s.rate_y));
        if (turn > TURN_LIMIT) begin
            turn = TURN_LIMIT;
        end
        if (turn > peak_rate) begin
            peak_rate = turn[TURN_W-1:0];
        end
        r.samples_seen   = trip_count;
        r.distance_total = (dist_acc > DIST_LIMIT) ? DIST_LIMIT[DIST_W-1:0] : dist_acc[DIST_W-1:0];
        r.mean_speed     = mean[MEAN_W-1:0];
        r.peak_turn      = peak_rate;
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR: %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results, field, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_ots_out due;
        if (!i_rst_n) begin
            last_x     = '0;
            last_y     = '0;
            trip_count = '0;
            dist_acc   = '0;
            speed_acc  = '0;
            peak_rate  = '0;
            mismatches = 0;
            results    = 0;
            stats_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                advance_trip(i_in, due);
                stats_due.push_back(due);
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (stats_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results));
                end else begin
                    due = stats_due.pop_front();
                    check_field("samples_seen", i_out.samples_seen, due.samples_seen);
                    check_field("distance_total", i_out.distance_total, due.distance_total);
                    check_field("mean_speed", i_out.mean_speed, due.mean_speed);
                    check_field("peak_turn", i_out.peak_turn, due.peak_turn);
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= stats_due.size();
        o_results     <= results;
    end

endmodule

// ===== tb/sv/tb_odometry_trip_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry trip statistics testbench
// Drives directed corner samples and then random walks, full-range noise and
// corner mixes into the trip statistics block, with random idle cycles on
// the request side and random stalls on the result side. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_odometry_trip_statistics;
    import ots_pkg::*;

    localparam int LIMIT_NS       = 12_000_000;
    localparam int RANDOM_SAMPLES = 800;
    localparam int DRAIN_CYCLES   = 150;

    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_ONE = 32'sh0001_0000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_ots_in  in_req;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_ots_out out_rsp;

    logic                          steady_in = 1'b0;
    int                            cycle_no  = 0;
    int                            sent      = 0;
    logic signed [COORD_WIDTH-1:0] walk_x    = '0;
    logic signed [COORD_WIDTH-1:0] walk_y    = '0;
    int                            mismatches;
    int                            outstanding;
    int                            checked;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    odometry_trip_statistics u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp)
    );

    ots_trip_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_rsp),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (checked)
    );

    // The result side takes everything during one long window.
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 30000 && cycle_no < 45000) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 32);
        end
    end

    task automatic send(input t_ots_in req);
        if (!steady_in) begin
            while ($urandom_range(99) < 32) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic send_fields(input logic signed [COORD_WIDTH-1:0] px, py, vx, vy, rx, ry);
        t_ots_in req;
        req.pos_x  = px;
        req.pos_y  = py;
        req.vel_x  = vx;
        req.vel_y  = vy;
        req.rate_x = rx;
        req.rate_y = ry;
        send(req);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] corner_value();
        case ($urandom_range(6))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            4: return 1;
            5: return C_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_random();
        t_ots_in req;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            walk_x     = walk_x + jitter(1 << 18);
            walk_y     = walk_y + jitter(1 << 18);
            req.pos_x  = walk_x;
            req.pos_y  = walk_y;
            req.vel_x  = jitter(5 << 16);
            req.vel_y  = jitter(5 << 16);
            req.rate_x = jitter((pick < 5) ? (1 << 28) : (3 << 16));
            req.rate_y = jitter((pick < 5) ? (1 << 28) : (3 << 16));
        end else if (pick < 80) begin
            req = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            req.pos_x  = corner_value();
            req.pos_y  = corner_value();
            req.vel_x  = corner_value();
            req.vel_y  = corner_value();
            req.rate_x = corner_value();
            req.rate_y = corner_value();
        end
        send(req);
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_req   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The first sample adds no distance; later ones cover the widest steps and
        // speeds, exact and rounded lengths, and a turn rate that only ties the peak.
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_fields(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_fields(C_MIN, C_MIN, 0, 0, C_MIN, C_MIN);
        send_fields(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
        send_fields(C_MIN, C_MAX, -1, 1, -1, 1);
        send_fields(-1, -1, 1, -1, C_MAX, 0);
        send_fields(0, 0, 3 * C_ONE, 4 * C_ONE, 3 * C_ONE, -4 * C_ONE);
        send_fields(3 * C_ONE, -4 * C_ONE, -3 * C_ONE, 4 * C_ONE, 0, 0);
        send_fields(3 * C_ONE + 1, -4 * C_ONE, 1, 1, 1, 1);
        send_fields(C_MAX, 0, C_MIN, 0, 0, C_MIN);
        send_fields(C_MIN, 0, 0, C_MIN, C_MIN, 0);
        send_fields(C_MIN, 0, C_MAX, C_MIN, 0, 0);
        send_fields(0, C_MAX, 0, 0, 0, C_MAX);

        repeat (RANDOM_SAMPLES) begin
            steady_in = (sent >= 300 && sent < 420);
            send_random();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d odometry samples: corner values, random walks and full-range noise.",
                 sent);
        $display("Checked %0d statistics results under random idling and output stalls.",
                 checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("ERROR: run did not complete within the time limit");
        $display("Mismatches found");
        $finish;
    end

endmodule
